// File: design/lpnu_pkg.sv
// Package for the label propagation node update core.
// Holds widths, depths and item kind codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lpnu_pkg;
	localparam int NODE_W   = 10;
	localparam int SLOT_W   = 12;
	localparam int DEG_W    = 7;
	localparam int LABEL_W  = 10;
	localparam int NODES      = 1024;
	localparam int EDGE_SLOTS = 4096;
	localparam logic [DEG_W-1:0] MAX_DEGREE = 7'd64;

	localparam logic [1:0] KIND_EXTENT = 2'd0;
	localparam logic [1:0] KIND_SLOT   = 2'd1;
	localparam logic [1:0] KIND_VISIT  = 2'd2;
	localparam logic [1:0] KIND_LABEL  = 2'd3;
endpackage
`default_nettype wire

// File: design/label_propagation_node_update_core.sv
// Label propagation node update core: top level.
// A load result is valid from its accepting edge. A visit reads the extent, then for each neighbor
// counts its label (neighbor, label and count reads, count write), then zeroes those counts in a
// clearing pass over the same neighbors, then reads its own label and writes back.
// Only one transaction is handled at a time; the next is accepted once the result is taken.
// Reset: arst_n clears the sequencer and output valid, then a pass zeroes the whole
// count memory with the input stalled; the other stores are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module label_propagation_node_update_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    kind,
	input  wire logic [lpnu_pkg::NODE_W-1:0]   node,
	input  wire logic [lpnu_pkg::SLOT_W-1:0]   slot,
	input  wire logic [lpnu_pkg::DEG_W-1:0]    degree,
	input  wire logic [lpnu_pkg::LABEL_W-1:0]  value,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [lpnu_pkg::NODE_W-1:0]        node_out,
	output logic [lpnu_pkg::LABEL_W-1:0]       new_label,
	output logic                               changed,
	output logic [lpnu_pkg::DEG_W-1:0]         max_count
);
	// Sequencer states.
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_EXT   = 4'd1;  // extent memory read in flight
	localparam logic [3:0] ST_NB    = 4'd2;  // neighbor read issued
	localparam logic [3:0] ST_LBL   = 4'd3;  // label read issued
	localparam logic [3:0] ST_CNT   = 4'd4;  // count read issued
	localparam logic [3:0] ST_UPD   = 4'd5;  // count written, next neighbor
	localparam logic [3:0] ST_CLR   = 4'd6;  // clearing pass, neighbor read
	localparam logic [3:0] ST_CLRL  = 4'd7;  // clearing pass, label read
	localparam logic [3:0] ST_CLRW  = 4'd8;  // clearing pass, count entry zeroed
	localparam logic [3:0] ST_OWN   = 4'd9;  // own label read issued
	localparam logic [3:0] ST_DONE  = 4'd10; // write back, present result
	localparam logic [3:0] ST_OUT   = 4'd11; // wait for result to be taken
	localparam logic [3:0] ST_INIT  = 4'd12; // zeroing the count memory after reset

	logic [3:0] state_q;

	// Memories, all with registered (synchronous) read.
	logic [lpnu_pkg::SLOT_W-1:0]  start_mem [lpnu_pkg::NODES];
	logic [lpnu_pkg::DEG_W-1:0]   deg_mem   [lpnu_pkg::NODES];
	logic [lpnu_pkg::NODE_W-1:0]  nb_mem    [lpnu_pkg::EDGE_SLOTS];
	logic [lpnu_pkg::LABEL_W-1:0] lbl_mem   [lpnu_pkg::NODES];
	logic [lpnu_pkg::DEG_W-1:0]   cnt_mem   [lpnu_pkg::NODES];

	logic [lpnu_pkg::SLOT_W-1:0]  start_rd_q, slot_q, first_q;
	logic [lpnu_pkg::DEG_W-1:0]   deg_rd_q, n_q, k_q;
	logic [lpnu_pkg::NODE_W-1:0]  nb_rd_q, node_q;
	logic [lpnu_pkg::LABEL_W-1:0] lbl_rd_q, lbl_q, dom_q, clr_idx_q;
	logic [lpnu_pkg::DEG_W-1:0]   cnt_rd_q, best_q;

	// The input is taken only while the sequencer is idle, one transaction at a time.
	logic accept;
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	logic [lpnu_pkg::DEG_W-1:0] cnt_inc;
	assign cnt_inc = cnt_rd_q + 7'd1;

	// Extent memories: written by extent loads, read at the accepting edge of a visit.
	always_ff @(posedge clk) begin
		if (accept && kind == lpnu_pkg::KIND_EXTENT) begin
			start_mem[node] <= slot;
			deg_mem[node]   <= (degree > lpnu_pkg::MAX_DEGREE) ? lpnu_pkg::MAX_DEGREE : degree;
		end
		start_rd_q <= start_mem[node];
		deg_rd_q   <= deg_mem[node];
	end

	// Neighbor table, read at the running slot, which wraps at the table size.
	always_ff @(posedge clk) begin
		if (accept && kind == lpnu_pkg::KIND_SLOT)
			nb_mem[slot] <= value;
		nb_rd_q <= nb_mem[slot_q];
	end

	// Label memory: neighbor labels during both passes, the node's own label otherwise.
	// The write-back comes after the clearing pass, so both passes see the old labels.
	logic [lpnu_pkg::NODE_W-1:0] lbl_addr;
	always_comb begin
		case (state_q)
			ST_LBL, ST_CLRL: lbl_addr = nb_rd_q;
			default:         lbl_addr = node_q;
		endcase
	end
	always_ff @(posedge clk) begin
		if (accept && kind == lpnu_pkg::KIND_LABEL)
			lbl_mem[node] <= value;
		else if (state_q == ST_DONE)
			lbl_mem[node_q] <= dom_q;
		lbl_rd_q <= lbl_mem[lbl_addr];
	end

	// Count memory: one write port shared by the increment, the clearing pass and the
	// zeroing pass after reset. The next count is read only after the previous write has
	// landed (states NB, LBL and CNT lie between), so repeated labels always see the updated count.
	logic                         cnt_we;
	logic [lpnu_pkg::LABEL_W-1:0] cnt_waddr;
	logic [lpnu_pkg::DEG_W-1:0]   cnt_wdata;
	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = lbl_q;
		cnt_wdata = cnt_inc;
		case (state_q)
			ST_UPD: begin
				cnt_we = 1'b1;
			end
			ST_CLRW: begin
				cnt_we    = 1'b1;
				cnt_waddr = lbl_rd_q;
				cnt_wdata = '0;
			end
			ST_INIT: begin
				cnt_we    = 1'b1;
				cnt_waddr = clr_idx_q;
				cnt_wdata = '0;
			end
			default: cnt_we = 1'b0;
		endcase
	end
	always_ff @(posedge clk) begin
		if (cnt_we)
			cnt_mem[cnt_waddr] <= cnt_wdata;
		cnt_rd_q <= cnt_mem[lbl_rd_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			out_valid <= 1'b0;
			node_out  <= '0;
			new_label <= '0;
			changed   <= 1'b0;
			max_count <= '0;
			node_q    <= '0;
			dom_q     <= '0;
			best_q    <= '0;
			k_q       <= '0;
			n_q       <= '0;
			slot_q    <= '0;
			first_q   <= '0;
			lbl_q     <= '0;
			clr_idx_q <= '0;
		end else begin
			case (state_q)
				ST_INIT: begin
					clr_idx_q <= clr_idx_q + 10'd1;
					if (&clr_idx_q)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						node_q    <= node;
						new_label <= '0;
						changed   <= 1'b0;
						max_count <= '0;
						node_out  <= node;
						dom_q     <= '0;
						best_q    <= '0;
						k_q       <= '0;
						if (kind == lpnu_pkg::KIND_VISIT) begin
							state_q <= ST_EXT;
						end else begin
							// Loads are done at the accepting edge.
							out_valid <= 1'b1;
							state_q   <= ST_OUT;
						end
					end
				end
				ST_EXT: begin
					n_q     <= deg_rd_q;
					slot_q  <= start_rd_q;
					first_q <= start_rd_q;
					state_q <= (deg_rd_q == '0) ? ST_OWN : ST_NB;
				end
				ST_NB: state_q <= ST_LBL;
				ST_LBL: state_q <= ST_CNT;
				ST_CNT: begin
					lbl_q   <= lbl_rd_q;
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					// Strictly greater: on a tie the label that got ahead first stays.
					if (cnt_inc > best_q) begin
						best_q <= cnt_inc;
						dom_q  <= lbl_q;
					end
					if (k_q + 7'd1 == n_q) begin
						// The clearing pass walks the same neighbors again.
						k_q     <= '0;
						slot_q  <= first_q;
						state_q <= ST_CLR;
					end else begin
						k_q     <= k_q + 7'd1;
						slot_q  <= slot_q + 12'd1;
						state_q <= ST_NB;
					end
				end
				ST_CLR: state_q <= ST_CLRL;
				ST_CLRL: state_q <= ST_CLRW;
				ST_CLRW: begin
					if (k_q + 7'd1 == n_q) begin
						state_q <= ST_OWN;
					end else begin
						k_q     <= k_q + 7'd1;
						slot_q  <= slot_q + 12'd1;
						state_q <= ST_CLR;
					end
				end
				ST_OWN: state_q <= ST_DONE;
				ST_DONE: begin
					new_label <= dom_q;
					changed   <= (lbl_rd_q != dom_q);
					max_count <= best_q;
					out_valid <= 1'b1;
					state_q   <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: design/lpnu_checker.sv
// Port-level checker for the label propagation node update core.
// Depends on lpnu_pkg; bound to the top level below.
`timescale 1ns / 1ps
`default_nettype none
module lpnu_core_props (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [lpnu_pkg::DEG_W-1:0] max_count
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while result pending");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> max_count <= lpnu_pkg::MAX_DEGREE) else $error("count too large");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("accepted without going busy");
endmodule

bind label_propagation_node_update_core lpnu_core_props u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .max_count(max_count)
);
`default_nettype wire

// File: tb/lpnu_checker.sv
// Checker for the label propagation node update core.
// Watches both channels, predicts each result and compares it field by field.
// Depends on lpnu_pkg for widths and item kind codes.
`timescale 1ns / 1ps
module lpnu_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_stall,
	input  wire logic [1:0]                    kind,
	input  wire logic [lpnu_pkg::NODE_W-1:0]   node,
	input  wire logic [lpnu_pkg::SLOT_W-1:0]   slot,
	input  wire logic [lpnu_pkg::DEG_W-1:0]    degree,
	input  wire logic [lpnu_pkg::LABEL_W-1:0]  value,
	input  wire logic                          out_valid,
	input  wire logic                          out_stall,
	input  wire logic [lpnu_pkg::NODE_W-1:0]   node_out,
	input  wire logic [lpnu_pkg::LABEL_W-1:0]  new_label,
	input  wire logic                          changed,
	input  wire logic [lpnu_pkg::DEG_W-1:0]    max_count,
	output int                                 errors,
	output int                                 pending
);
	typedef struct {
		logic [lpnu_pkg::NODE_W-1:0]  node;
		logic [lpnu_pkg::LABEL_W-1:0] label;
		logic                         changed;
		logic [lpnu_pkg::DEG_W-1:0]   count;
	} update_t;

	logic [lpnu_pkg::SLOT_W-1:0]  first_slot [lpnu_pkg::NODES];
	logic [lpnu_pkg::DEG_W-1:0]   node_degree [lpnu_pkg::NODES];
	logic [lpnu_pkg::NODE_W-1:0]  adjacency [lpnu_pkg::EDGE_SLOTS];
	logic [lpnu_pkg::LABEL_W-1:0] node_label [lpnu_pkg::NODES];
	update_t                      update_q [$];

	initial begin
		errors = 0;
		pending = 0;
	end

	// Applies one transaction to the mirrored graph and returns the update it reports.
	function automatic update_t apply_item(logic [1:0] k, logic [lpnu_pkg::NODE_W-1:0] n,
			logic [lpnu_pkg::SLOT_W-1:0] s, logic [lpnu_pkg::DEG_W-1:0] d,
			logic [lpnu_pkg::LABEL_W-1:0] v);
		update_t                      u;
		int                           tally [lpnu_pkg::NODES];
		int                           hops;
		int                           best;
		logic [lpnu_pkg::LABEL_W-1:0] lbl;
		logic [lpnu_pkg::SLOT_W-1:0]  sl;
		u = '{node: n, label: '0, changed: 1'b0, count: '0};
		best = 0;
		case (k)
			lpnu_pkg::KIND_EXTENT: begin
				first_slot[n] = s;
				node_degree[n] = (d > lpnu_pkg::MAX_DEGREE) ? lpnu_pkg::MAX_DEGREE : d;
			end
			lpnu_pkg::KIND_SLOT: adjacency[s] = v;
			lpnu_pkg::KIND_LABEL: node_label[n] = v;
			default: begin
				foreach (tally[i]) tally[i] = 0;
				hops = node_degree[n];
				for (int i = 0; i < hops; i++) begin
					sl = first_slot[n] + i[lpnu_pkg::SLOT_W-1:0];
					lbl = node_label[adjacency[sl]];
					tally[lbl]++;
					if (tally[lbl] > best) begin
						best = tally[lbl];
						u.label = lbl;
					end
				end
				u.count = best[lpnu_pkg::DEG_W-1:0];
				if (node_label[n] != u.label) begin
					node_label[n] = u.label;
					u.changed = 1'b1;
				end
			end
		endcase
		return u;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		update_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (update_q.size() == 0) begin
					report_mismatch("unexpected result, node", node_out, -1);
				end else begin
					want = update_q.pop_front();
					pending--;
					if (node_out !== want.node)
						report_mismatch("node_out", node_out, want.node);
					if (new_label !== want.label)
						report_mismatch("new_label", new_label, want.label);
					if (changed !== want.changed)
						report_mismatch("changed", changed, want.changed);
					if (max_count !== want.count)
						report_mismatch("max_count", max_count, want.count);
				end
			end
			if (in_valid && !in_stall) begin
				update_q.push_back(apply_item(kind, node, slot, degree, value));
				pending++;
			end
		end
	end
endmodule

// File: tb/label_propagation_node_update_core_tb.sv
// Testbench top for the label propagation node update core.
// Drives graph loads and visits under varied idling and stalls; the checker
// module does all prediction. Depends on lpnu_pkg, lpnu_checker and the core.
`timescale 1ns / 1ps
module label_propagation_node_update_core_tb;
	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic [1:0]                    kind;
	logic [lpnu_pkg::NODE_W-1:0]   node;
	logic [lpnu_pkg::SLOT_W-1:0]   slot;
	logic [lpnu_pkg::DEG_W-1:0]    degree;
	logic [lpnu_pkg::LABEL_W-1:0]  value;
	logic                          out_valid;
	logic                          out_stall;
	logic [lpnu_pkg::NODE_W-1:0]   node_out;
	logic [lpnu_pkg::LABEL_W-1:0]  new_label;
	logic                          changed;
	logic [lpnu_pkg::DEG_W-1:0]    max_count;
	int                            errors;
	int                            pending;

	// Idling knobs, in percent of cycles, changed from phase to phase.
	int                            send_idle_pct;
	int                            recv_stall_pct;
	// A long receiver hold-off is requested by the stimulus and counted down
	// by the receiver process itself.
	logic                          hold_req;
	int                            hold_left;

	// The stimulus keeps its own record of what has been written, so that a
	// visit is only issued when every entry it reads has been written before.
	bit                            extent_known [lpnu_pkg::NODES];
	bit                            label_known [lpnu_pkg::NODES];
	bit                            slot_known [lpnu_pkg::EDGE_SLOTS];
	logic [lpnu_pkg::SLOT_W-1:0]   plan_first [lpnu_pkg::NODES];
	int                            plan_degree [lpnu_pkg::NODES];
	logic [lpnu_pkg::NODE_W-1:0]   plan_adj [lpnu_pkg::EDGE_SLOTS];
	int                            labeled_nodes [$];
	int                            built_nodes [$];
	int                            items_sent;

	label_propagation_node_update_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .node(node), .slot(slot), .degree(degree), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.node_out(node_out), .new_label(new_label), .changed(changed),
		.max_count(max_count)
	);

	lpnu_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .node(node), .slot(slot), .degree(degree), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.node_out(node_out), .new_label(new_label), .changed(changed),
		.max_count(max_count), .errors(errors), .pending(pending)
	);

	always #5 clk = ~clk;

	// The receiver stalls at random, or holds off for a long stretch on request
	// so that results back up into the core and it has to stall its input.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_req) begin
			hold_left <= 400;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// The run ends here if the core hangs.
	initial begin
		#200_000_000;
		$display("FAILURE");
		$finish;
	end

	// Offers one transaction and returns once the core has taken it. Valid is
	// left high so that back-to-back transactions need no extra assignment.
	task automatic send_item(input logic [1:0] k, input int n, input int s,
			input int d, input int v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		node <= n[lpnu_pkg::NODE_W-1:0];
		slot <= s[lpnu_pkg::SLOT_W-1:0];
		degree <= d[lpnu_pkg::DEG_W-1:0];
		value <= v[lpnu_pkg::LABEL_W-1:0];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		case (k)
			lpnu_pkg::KIND_EXTENT: begin
				extent_known[n] = 1'b1;
				plan_first[n] = s[lpnu_pkg::SLOT_W-1:0];
				plan_degree[n] = (d[lpnu_pkg::DEG_W-1:0] > 64) ? 64 : d[lpnu_pkg::DEG_W-1:0];
			end
			lpnu_pkg::KIND_SLOT: begin
				slot_known[s] = 1'b1;
				plan_adj[s] = v[lpnu_pkg::NODE_W-1:0];
			end
			lpnu_pkg::KIND_LABEL: begin
				if (!label_known[n])
					labeled_nodes.push_back(n);
				label_known[n] = 1'b1;
			end
			default: ;
		endcase
	endtask

	// Stops offering work until every expected result has come back.
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// A visit is legal only if the node's extent and label, every slot of its
	// extent, and the label of every neighbor found there have been written.
	function automatic bit visit_ok(int n);
		int sl;
		if (!extent_known[n] || !label_known[n])
			return 1'b0;
		for (int i = 0; i < plan_degree[n]; i++) begin
			sl = (plan_first[n] + i) % lpnu_pkg::EDGE_SLOTS;
			if (!slot_known[sl] || !label_known[plan_adj[sl]])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Loads one node with its neighbor list and visits it. Neighbors come from
	// the given list first and from already labeled nodes after that.
	task automatic build_and_visit(input int n, input int first, input int deg,
			input int own, input int adj [$]);
		int hops;
		int nb;
		hops = (deg > 64) ? 64 : deg;
		send_item(lpnu_pkg::KIND_LABEL, n, $urandom_range(4095), $urandom_range(127), own);
		send_item(lpnu_pkg::KIND_EXTENT, n, first, deg, $urandom_range(1023));
		for (int i = 0; i < hops; i++) begin
			nb = (i < adj.size()) ? adj[i]
				: labeled_nodes[$urandom_range(labeled_nodes.size() - 1)];
			send_item(lpnu_pkg::KIND_SLOT, $urandom_range(1023),
				(first + i) % lpnu_pkg::EDGE_SLOTS, $urandom_range(127), nb);
		end
		send_item(lpnu_pkg::KIND_VISIT, n, $urandom_range(4095), $urandom_range(127),
			$urandom_range(1023));
		built_nodes.push_back(n);
	endtask

	// One random phase: mostly complete load-and-visit sequences with random
	// shape, plus revisits and loose transactions of every kind.
	task automatic random_phase(input int quota, input bit with_hold);
		int goal;
		int pick;
		int n;
		int deg;
		int adj [$];
		goal = items_sent + quota;
		while (items_sent < goal) begin
			pick = $urandom_range(99);
			if (with_hold && items_sent > goal - quota / 2 && !hold_req && hold_left == 0) begin
				// Long receiver hold-off while the sender keeps going.
				hold_req <= 1'b1;
				@(posedge clk);
				hold_req <= 1'b0;
				with_hold = 1'b0;
			end
			if (pick < 55) begin
				pick = $urandom_range(99);
				deg = (pick < 80) ? $urandom_range(8)
					: (pick < 95) ? $urandom_range(64) : $urandom_range(127);
				build_and_visit($urandom_range(1023), $urandom_range(4095), deg,
					($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(7),
					adj);
			end else if (pick < 75) begin
				n = built_nodes[$urandom_range(built_nodes.size() - 1)];
				if (visit_ok(n))
					send_item(lpnu_pkg::KIND_VISIT, n, $urandom_range(4095),
						$urandom_range(127), $urandom_range(1023));
				else
					send_item(lpnu_pkg::KIND_LABEL, n, 0, 0, $urandom_range(7));
			end else begin
				pick = $urandom_range(3);
				n = $urandom_range(1023);
				if (pick == lpnu_pkg::KIND_VISIT && !visit_ok(n))
					pick = lpnu_pkg::KIND_LABEL;
				send_item(pick[1:0], n, $urandom_range(4095), $urandom_range(127),
					(pick == lpnu_pkg::KIND_LABEL) ? $urandom_range(1023)
					: labeled_nodes[$urandom_range(labeled_nodes.size() - 1)]);
			end
		end
	endtask

	initial begin
		int adj [$];
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = lpnu_pkg::KIND_EXTENT;
		node = '0;
		slot = '0;
		degree = '0;
		value = '0;
		out_stall = 1'b0;
		hold_req = 1'b0;
		hold_left = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		items_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Seed labels: the small ones 0 to 7, the largest label value 1023 and the middle value 512.
		for (int i = 0; i < 8; i++)
			send_item(lpnu_pkg::KIND_LABEL, i, 0, 0, i);
		send_item(lpnu_pkg::KIND_LABEL, 1023, 4095, 127, 1023);
		send_item(lpnu_pkg::KIND_LABEL, 512, 2048, 64, 512);

		// A node without neighbors takes label zero; a second visit changes nothing.
		adj = {};
		build_and_visit(100, 0, 0, 7, adj);
		send_item(lpnu_pkg::KIND_VISIT, 100, 0, 0, 0);

		// Degree above the limit saturates; all neighbors agree, so the count is full.
		adj = {};
		for (int i = 0; i < 64; i++)
			adj.push_back(1023);
		build_and_visit(1000, 0, 127, 3, adj);

		// A tie is won by the label that first pulls ahead; the extent wraps
		// past the last slot of the neighbor table.
		adj = {1, 2, 2, 1};
		build_and_visit(200, 4094, 4, 512, adj);

		// Phases of random work, each with its own idling pattern.
		random_phase(400, 1'b1);
		drain();
		send_idle_pct = 76;
		random_phase(400, 1'b0);
		drain();
		send_idle_pct = 0;
		recv_stall_pct = 76;
		random_phase(400, 1'b1);
		drain();
		send_idle_pct = 35;
		recv_stall_pct = 35;
		random_phase(400, 1'b0);

		// Let the last results come out and allow for a late stray result.
		drain();
		repeat (300) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
